// ===== rtl/tps_pkg.sv =====
// Shared constants and controller/datapath interface types of the timed phase sequencer.
`default_nettype none
package tps_pkg;

  localparam int NUM_PHASES = 8;
  localparam int DUR_W      = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int IN_TIME_W  = 32;
  localparam int KIND_W     = 2;
  localparam int PHASE_W    = 3;
  localparam int PROG_W     = 17;
  localparam int ERR_W      = 2;
  localparam int PSTATE_W   = 4;

  // Event kinds.
  localparam logic [KIND_W-1:0] EV_START = 2'd0;
  localparam logic [KIND_W-1:0] EV_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] EV_CLOSE = 2'd2;
  localparam logic [KIND_W-1:0] EV_ERROR = 2'd3;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RESTART     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NOT_STARTED = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BACKWARDS   = 2'd3;

  // Phase state codes: newborn, first phase, ended.
  localparam logic [PSTATE_W-1:0] ST_NEWBORN = 4'd0;
  localparam logic [PSTATE_W-1:0] ST_FIRST   = 4'd1;
  localparam logic [PSTATE_W-1:0] ST_ENDED   = 4'd9;

  // Progress source of an emitted event.
  localparam logic [1:0] PROG_ZERO = 2'd0;
  localparam logic [1:0] PROG_FULL = 2'd1;
  localparam logic [1:0] PROG_QUOT = 2'd2;

  typedef struct packed {
    logic              latch;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic [ERR_W-1:0]  err;
    logic [1:0]        prog_sel;
    logic              last;
    logic              init;
    logic              advance;
    logic              div_load;
    logic              div_step;
  } tps_cmd_t;

  typedef struct packed {
    logic func;
    logic newborn;
    logic ended;
    logic t_lt_start;
    logic e_zero;
    logic e_lt_d;
    logic final_phase;
    logic div_done;
    logic out_free;
  } tps_sts_t;

endpackage
`default_nettype wire

// ===== rtl/tps_ctrl.sv =====
// Controller state machine of the timed phase sequencer.
`default_nettype none
module tps_ctrl
  import tps_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire tps_sts_t sts_i,
  output tps_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_EVAL     = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_FRAC     = 3'd4;
  localparam logic [2:0] S_FULL     = 3'd5;
  localparam logic [2:0] S_CLOSE    = 3'd6;

  logic [2:0] state_q, state_d;
  logic       pend_q, pend_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (!sts_i.func) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.last = 1'b1;
            if (sts_i.newborn) begin
              cmd_o.kind = EV_START;
              cmd_o.init = 1'b1;
            end else begin
              cmd_o.kind = EV_ERROR;
              cmd_o.err  = ERR_RESTART;
            end
            state_d = S_IDLE;
          end
        end else if (sts_i.newborn) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.last = 1'b1;
            cmd_o.kind = EV_ERROR;
            cmd_o.err  = ERR_NOT_STARTED;
            state_d    = S_IDLE;
          end
        end else if (sts_i.ended) begin
          state_d = S_IDLE;
        end else if (sts_i.t_lt_start) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.last = 1'b1;
            cmd_o.kind = EV_ERROR;
            cmd_o.err  = ERR_BACKWARDS;
            state_d    = S_IDLE;
          end
        end else begin
          pend_d  = 1'b0;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        // A pending start event is last only if the new phase has no elapsed time.
        priority if (pend_q) begin
          if (sts_i.out_free) begin
            cmd_o.emit = 1'b1;
            cmd_o.kind = EV_START;
            cmd_o.last = sts_i.e_zero;
            pend_d     = 1'b0;
            if (sts_i.e_zero) begin
              state_d = S_IDLE;
            end
          end
        end else if (sts_i.e_zero) begin
          state_d = S_IDLE;
        end else if (sts_i.e_lt_d) begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end else begin
          state_d = S_FULL;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_FRAC;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_FRAC: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = EV_RUN;
          cmd_o.prog_sel = PROG_QUOT;
          cmd_o.last     = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FULL: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = EV_RUN;
          cmd_o.prog_sel = PROG_FULL;
          state_d        = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (sts_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = EV_CLOSE;
          cmd_o.last    = sts_i.final_phase;
          cmd_o.advance = 1'b1;
          if (sts_i.final_phase) begin
            state_d = S_IDLE;
          end else begin
            pend_d  = 1'b1;
            state_d = S_EVAL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tps_dp.sv =====
// Datapath of the timed phase sequencer: durations, phase state, divider and output register.
`default_nettype none
module tps_dp
  import tps_pkg::*;
#(
  parameter int TIME_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DUR_W-1:0]     cfg_data_i,
  input  wire logic                 in_func_i,
  input  wire logic [IN_TIME_W-1:0] in_time_i,
  input  wire tps_cmd_t             cmd_i,
  output tps_sts_t                  sts_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [KIND_W-1:0]         out_kind_o,
  output logic [PHASE_W-1:0]        out_phase_o,
  output logic [PROG_W-1:0]         out_prog_o,
  output logic [ERR_W-1:0]          out_err_o,
  output logic                      out_last_o
);

  localparam int CMP_W = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [FRAC_BITS:0] FULL = {1'b1, {FRAC_BITS{1'b0}}};

  logic [DUR_W-1:0]     dur_q [NUM_PHASES];
  logic [PSTATE_W-1:0]  pstate_q;
  logic [TIME_BITS-1:0] start_q;
  logic                 func_q;
  logic [TIME_BITS-1:0] time_q;
  logic [DUR_W-1:0]     rem_q;
  logic [DUR_W-1:0]     divisor_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 out_valid_q;
  logic [KIND_W-1:0]    out_kind_q;
  logic [PHASE_W-1:0]   out_phase_q;
  logic [PROG_W-1:0]    out_prog_q;
  logic [ERR_W-1:0]     out_err_q;
  logic                 out_last_q;

  logic [PHASE_W-1:0]   phase_idx;
  logic [DUR_W-1:0]     cur_dur;
  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     e_ext, d_ext;
  logic [DUR_W:0]       rem_shift;
  logic                 div_ge;
  logic                 out_free;
  logic [PROG_W-1:0]    prog_sel;

  assign phase_idx = PHASE_W'(pstate_q - 4'd1);
  assign cur_dur   = dur_q[phase_idx];
  assign elapsed   = time_q - start_q;
  assign e_ext     = CMP_W'(elapsed);
  assign d_ext     = CMP_W'(cur_dur);
  assign rem_shift = {rem_q, 1'b0};
  assign div_ge    = rem_shift >= {1'b0, divisor_q};
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.func        = func_q;
    sts_o.newborn     = (pstate_q == ST_NEWBORN);
    sts_o.ended       = (pstate_q >= ST_ENDED);
    sts_o.t_lt_start  = (time_q < start_q);
    sts_o.e_zero      = (elapsed == '0);
    sts_o.e_lt_d      = (e_ext < d_ext);
    sts_o.final_phase = (phase_idx == PHASE_W'(NUM_PHASES - 1));
    sts_o.div_done    = (cnt_q == '0);
    sts_o.out_free    = out_free;
  end

  always_comb begin
    unique case (cmd_i.prog_sel)
      PROG_FULL: prog_sel = PROG_W'(FULL);
      PROG_QUOT: prog_sel = PROG_W'(quo_q);
      default:   prog_sel = '0;
    endcase
  end

  // Control state: durations, phase tracking, divider count, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PHASES; i++) begin
        dur_q[i] <= '0;
      end
      pstate_q    <= ST_NEWBORN;
      start_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && !cfg_idx_i[CFG_IDX_W-1]) begin
        dur_q[cfg_idx_i[PHASE_W-1:0]] <= cfg_data_i;
      end
      if (cmd_i.init) begin
        start_q  <= time_q;
        pstate_q <= ST_FIRST;
      end else if (cmd_i.advance) begin
        start_q  <= start_q + TIME_BITS'(cur_dur);
        pstate_q <= sts_o.final_phase ? ST_ENDED : pstate_q + 4'd1;
      end
      if (cmd_i.div_load) begin
        cnt_q <= CNT_W'(FRAC_BITS);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: latched item, restoring divider, output fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= in_func_i;
      time_q <= TIME_BITS'(in_time_i);
    end
    if (cmd_i.div_load) begin
      rem_q     <= DUR_W'(e_ext);
      divisor_q <= cur_dur;
      quo_q     <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? DUR_W'(rem_shift - {1'b0, divisor_q}) : DUR_W'(rem_shift);
      quo_q <= {quo_q[FRAC_BITS-2:0], div_ge};
    end
    if (cmd_i.emit) begin
      out_kind_q  <= cmd_i.kind;
      out_phase_q <= (cmd_i.kind == EV_ERROR || cmd_i.init) ? '0 : phase_idx;
      out_prog_q  <= prog_sel;
      out_err_q   <= cmd_i.err;
      out_last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_phase_o = out_phase_q;
  assign out_prog_o  = out_prog_q;
  assign out_err_o   = out_err_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/timed_phase_sequencer.sv =====
// Timed phase sequencer top level: stream ports, configuration port, controller and datapath.
// A start or error item is settled in the dispatch state; its beat is loaded once the output register is free.
// Each crossed boundary passes the full, close and evaluate states (run, close and start beats and a new
// evaluation); a partly elapsed phase adds the bit-serial progress divider and the fraction state.
// Throughput: one item at a time; the next item is taken once the previous one's beats are queued.
// Reset: asynchronous, active low; durations clear to zero and the sequencer returns to newborn.
`default_nettype none
module timed_phase_sequencer
  import tps_pkg::*;
#(
  parameter int TIME_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port; index i (0 to 7) selects the duration of phase i; higher indices are ignored.
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DUR_W-1:0]     cfg_data_i,
  // Input stream.
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [31:0]          s_axis_tdata,   // [31:0] current_time
  input  wire logic [0:0]           s_axis_tuser,   // [0] func
  // Output stream.
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // [2:0] phase_index, [19:3] progress,
                                                    // [21:20] err_code, [23:22] zero
  output logic [1:0]                m_axis_tuser,   // [1:0] event_kind
  output logic                      m_axis_tlast
);

  // The controller holds only its state and walks one event at a time; the datapath holds the rest of
  // the stored state and the single output register, so the next event is prepared while a beat waits downstream.
  tps_cmd_t           cmd;
  tps_sts_t           sts;
  logic [PHASE_W-1:0] out_phase;
  logic [PROG_W-1:0]  out_prog;
  logic [ERR_W-1:0]   out_err;

  tps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tps_dp #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_func_i   (s_axis_tuser[0]),
    .in_time_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_kind_o  (m_axis_tuser),
    .out_phase_o (out_phase),
    .out_prog_o  (out_prog),
    .out_err_o   (out_err),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_err, out_prog, out_phase};

  // An error always ends the beats of its item.
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == EV_ERROR) |-> m_axis_tlast)
    else $error("error beat without tlast");

  // Only run events carry progress.
  a_prog_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != EV_RUN) |-> (out_prog == '0))
    else $error("progress on a non-run beat");

  // After taking an item the sequencer is not ready in the following cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // Error beats concern no phase and carry an error code.
  a_err_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == EV_ERROR) |-> (out_phase == '0 && out_err != ERR_NONE))
    else $error("malformed error beat");

endmodule
`default_nettype wire
